// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/fbd_pkg.sv =====
// Package for the five-button debounce/autorepeat block: widths, defaults,
// register indexes and lane structs. No dependencies.
package fbd_pkg;

    localparam int BTN_W           = 5;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int NUM_BUTTONS_DEF = 5;
    localparam int TIMER_BITS_DEF  = 8;

    localparam logic [CFG_W-1:0] VALID_TIME_RST    = 8'd3;
    localparam logic [CFG_W-1:0] WAIT_TIME_RST     = 8'd3;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALID_TIME    = 2'd0,
        CFG_WAIT_TIME     = 2'd1,
        CFG_REPEAT_PERIOD = 2'd2
    } t_cfg_idx;

    // per-lane result of one tick
    typedef struct packed {
        logic changed;
        logic load_rep;
        logic qual;
    } t_lane_ev;

    // per-lane stored levels
    typedef struct packed {
        logic qual;
        logic prev;
    } t_lane_st;

endpackage

// ===== hw/rtl/fbd_in_if.sv =====
// Input channel: valid/ready with the raw button levels.
// Depends on fbd_pkg.
interface fbd_in_if;
    logic                      valid;
    logic                      ready;
    logic [fbd_pkg::BTN_W-1:0] raw_buttons;

    modport source (output valid, output raw_buttons, input ready);
    modport sink   (input valid, input raw_buttons, output ready);
endinterface

// ===== hw/rtl/fbd_out_if.sv =====
// Output channel: valid/ready with qualified levels and change mask.
// Depends on fbd_pkg.
interface fbd_out_if;
    logic                      valid;
    logic                      ready;
    logic [fbd_pkg::BTN_W-1:0] held_buttons;
    logic [fbd_pkg::BTN_W-1:0] changed_buttons;

    modport source (output valid, output held_buttons, output changed_buttons, input ready);
    modport sink   (input valid, input held_buttons, input changed_buttons, output ready);
endinterface

// ===== hw/rtl/fbd_lane.sv =====
// One button lane: release and press countdowns, qualified level, last raw level.
// Depends on fbd_pkg.
module fbd_lane #(
    parameter int TIMER_BITS = fbd_pkg::TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic                  i_now,
    input  logic [TIMER_BITS-1:0] i_valid_time,
    input  logic [TIMER_BITS-1:0] i_wait_time,
    output fbd_pkg::t_lane_ev     o_ev,
    output fbd_pkg::t_lane_st     o_st
);

    logic [TIMER_BITS-1:0] r_rel, n_rel;
    logic [TIMER_BITS-1:0] r_prs, n_prs;
    logic                  r_qual, n_qual;
    logic                  r_prev;
    logic                  w_chg, w_ld;

    always_comb begin
        n_rel  = (r_rel != '0) ? r_rel - TIMER_BITS'(1) : r_rel;
        n_prs  = r_prs;
        n_qual = r_qual;
        w_chg  = 1'b0;
        w_ld   = 1'b0;
        if (i_now) begin
            if (!r_prev) begin
                if (n_rel == '0) begin
                    n_prs = i_valid_time;
                end
            end else if (r_prs != '0) begin
                n_prs = r_prs - TIMER_BITS'(1);
                if (n_prs == '0) begin
                    n_qual = 1'b1;
                    w_chg  = 1'b1;
                    w_ld   = 1'b1;
                end
            end
        end else if (r_prev) begin
            if (r_prs == '0) begin
                n_qual = 1'b0;
                w_chg  = 1'b1;
            end
            w_ld  = 1'b1;
            n_rel = i_wait_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel  <= '0;
            r_prs  <= '0;
            r_qual <= 1'b0;
            r_prev <= 1'b0;
        end else if (i_acc) begin
            r_rel  <= n_rel;
            r_prs  <= n_prs;
            r_qual <= n_qual;
            r_prev <= i_now;
        end
    end

    assign o_ev.changed  = w_chg;
    assign o_ev.load_rep = w_ld;
    assign o_ev.qual     = n_qual;
    assign o_st.qual     = r_qual;
    assign o_st.prev     = r_prev;

endmodule

// ===== hw/rtl/fbd_merge.sv =====
// Merge stage: combines lane results, runs the shared repeat timer and holds
// the output register. Depends on fbd_pkg.
module fbd_merge #(
    parameter int NUM_BUTTONS = fbd_pkg::NUM_BUTTONS_DEF,
    parameter int TIMER_BITS  = fbd_pkg::TIMER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_acc,
    input  fbd_pkg::t_lane_ev         i_ev [NUM_BUTTONS],
    input  logic [TIMER_BITS-1:0]     i_repeat_period,
    input  logic                      i_out_ready,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output logic [fbd_pkg::BTN_W-1:0] o_held,
    output logic [fbd_pkg::BTN_W-1:0] o_changed
);

    logic [NUM_BUTTONS-1:0]    w_ld_vec;
    logic [NUM_BUTTONS-1:0]    w_chg_all;
    logic [fbd_pkg::BTN_W-1:0] w_held, w_chg;
    logic [TIMER_BITS-1:0]     r_rep, n_rep, w_rep_mid;
    logic                      w_fire, w_signal;
    logic                      r_out_valid;
    logic [fbd_pkg::BTN_W-1:0] r_held, r_chg;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        assign w_ld_vec[i]  = i_ev[i].load_rep;
        assign w_chg_all[i] = i_ev[i].changed;
    end

    for (genvar i = 0; i < fbd_pkg::BTN_W; i++) begin : g_bit
        if (i < NUM_BUTTONS) begin : g_used
            assign w_held[i] = i_ev[i].qual;
            assign w_chg[i]  = i_ev[i].changed;
        end else begin : g_unused
            assign w_held[i] = 1'b0;
            assign w_chg[i]  = 1'b0;
        end
    end

    always_comb begin
        w_rep_mid = (|w_ld_vec) ? i_repeat_period : r_rep;
        n_rep     = w_rep_mid;
        w_fire    = 1'b0;
        if (w_rep_mid != '0) begin
            n_rep = w_rep_mid - TIMER_BITS'(1);
            if (n_rep == '0) begin
                w_fire = 1'b1;
                n_rep  = i_repeat_period;
            end
        end
        w_signal = (|w_chg_all) || w_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_acc) begin
                r_rep <= n_rep;
            end
            if (i_acc && w_signal) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && w_signal) begin
            r_held <= w_held;
            r_chg  <= w_chg;
        end
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_held      = r_held;
    assign o_changed   = r_chg;

endmodule

// ===== hw/rtl/five_button_debounce_autorepeat_core.sv =====
// Five-button debounce with autorepeat: one lane per button plus a merge stage.
// A result beat is registered from its input beat and appears in the cycle after it.
// Throughput: one input beat per clock; ready falls only while a result beat
// waits in the single output register and the sink is not taking it.
// Reset: synchronous, active low; countdowns and levels clear, registers load 3, 3, 10.
// Depends on fbd_pkg, fbd_in_if, fbd_out_if, fbd_lane, fbd_merge, assert_macros.svh.
`include "assert_macros.svh"
module five_button_debounce_autorepeat_core #(
    parameter int NUM_BUTTONS = fbd_pkg::NUM_BUTTONS_DEF,
    parameter int TIMER_BITS  = fbd_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fbd_pkg::CFG_W-1:0]     i_cfg_data,
    fbd_in_if.sink                        i_in,
    fbd_out_if.source                     o_out
);

    localparam int EXT_W = TIMER_BITS + fbd_pkg::CFG_W;

    logic [fbd_pkg::CFG_W-1:0] r_valid_time, r_wait_time, r_repeat_period;
    logic [EXT_W-1:0]          w_vt_ext, w_wt_ext, w_rp_ext;
    logic [TIMER_BITS-1:0]     w_vt, w_wt, w_rp;
    logic                      w_in_ready, w_acc;
    fbd_pkg::t_lane_ev         w_ev [NUM_BUTTONS];
    fbd_pkg::t_lane_st         w_st [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]    w_qual, w_prev, w_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_time    <= fbd_pkg::VALID_TIME_RST;
            r_wait_time     <= fbd_pkg::WAIT_TIME_RST;
            r_repeat_period <= fbd_pkg::REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (fbd_pkg::t_cfg_idx'(i_cfg_idx))
                fbd_pkg::CFG_VALID_TIME:    r_valid_time    <= i_cfg_data;
                fbd_pkg::CFG_WAIT_TIME:     r_wait_time     <= i_cfg_data;
                fbd_pkg::CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero-extend then cut to the timer width
    assign w_vt_ext = {{TIMER_BITS{1'b0}}, r_valid_time};
    assign w_wt_ext = {{TIMER_BITS{1'b0}}, r_wait_time};
    assign w_rp_ext = {{TIMER_BITS{1'b0}}, r_repeat_period};
    assign w_vt     = w_vt_ext[TIMER_BITS-1:0];
    assign w_wt     = w_wt_ext[TIMER_BITS-1:0];
    assign w_rp     = w_rp_ext[TIMER_BITS-1:0];

    assign w_acc      = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        logic w_now;
        if (i < fbd_pkg::BTN_W) begin : g_raw
            assign w_now = i_in.raw_buttons[i];
        end else begin : g_none
            assign w_now = 1'b0;
        end

        fbd_lane #(
            .TIMER_BITS (TIMER_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_acc        (w_acc),
            .i_now        (w_now),
            .i_valid_time (w_vt),
            .i_wait_time  (w_wt),
            .o_ev         (w_ev[i]),
            .o_st         (w_st[i])
        );

        assign w_qual[i] = w_st[i].qual;
        assign w_prev[i] = w_st[i].prev;
        assign w_chg[i]  = w_ev[i].changed;
    end

    fbd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_acc           (w_acc),
        .i_ev            (w_ev),
        .i_repeat_period (w_rp),
        .i_out_ready     (o_out.ready),
        .o_in_ready      (w_in_ready),
        .o_out_valid     (o_out.valid),
        .o_held          (o_out.held_buttons),
        .o_changed       (o_out.changed_buttons)
    );

    // input stalls only behind a waiting result beat
    `FBD_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !w_in_ready, o_out.valid && !o_out.ready)
    // an accepted change always yields a result beat
    `FBD_ASSERT_NEXT(a_change_reported, i_clk, i_rst_n, w_acc && (|w_chg), o_out.valid)
    // a qualified button is one still held
    `FBD_ASSERT_IMPL(a_qual_held, i_clk, i_rst_n, 1'b1, (w_qual & ~w_prev) == '0)

endmodule

// ===== tb/sv/fbd_report_checker.sv =====
// Checker for the five-button debounce/autorepeat core: tracks the channels and
// register writes, predicts each report beat and compares it. Depends on fbd_pkg and both channel interfaces.
`timescale 1ns / 100ps
module fbd_report_checker
    import fbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    fbd_in_if                    in_ch,
    fbd_out_if                   out_ch,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_beats_in,
    output int                   o_beats_out
);

    typedef struct packed {
        logic [BTN_W-1:0] held;
        logic [BTN_W-1:0] changed;
    } button_report_t;

    logic [CFG_W-1:0] valid_ticks;
    logic [CFG_W-1:0] wait_ticks;
    logic [CFG_W-1:0] repeat_ticks;

    logic [7:0]       release_left [BTN_W];
    logic [7:0]       press_left   [BTN_W];
    logic [7:0]       repeat_left;
    logic [BTN_W-1:0] qual_levels;
    logic [BTN_W-1:0] prev_raw;

    button_report_t   reports_due [$];
    button_report_t   want;
    button_report_t   got;
    button_report_t   fresh;

    task automatic flag_mismatch(input string what);
        o_mismatches++;
        if (o_mismatches <= 20)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // one tick per accepted input beat; returns 1 when a report beat is due
    function automatic logic debounce_tick(input logic [BTN_W-1:0] raw,
                                           output button_report_t rpt);
        logic [BTN_W-1:0] chg;
        logic             sig;
        int               b;
        chg = '0;
        sig = 1'b0;
        for (b = 0; b < BTN_W; b++) begin
            if (release_left[b] != 0)
                release_left[b] = release_left[b] - 1'b1;
            if (raw[b]) begin
                if (!prev_raw[b]) begin
                    if (release_left[b] == 0)
                        press_left[b] = valid_ticks;
                end else if (press_left[b] != 0) begin
                    press_left[b] = press_left[b] - 1'b1;
                    if (press_left[b] == 0) begin
                        qual_levels[b] = 1'b1;
                        chg[b]         = 1'b1;
                        sig            = 1'b1;
                        repeat_left    = repeat_ticks;
                    end
                end
            end else if (prev_raw[b]) begin
                if (press_left[b] == 0) begin
                    qual_levels[b] = 1'b0;
                    chg[b]         = 1'b1;
                    sig            = 1'b1;
                end
                repeat_left     = repeat_ticks;
                release_left[b] = wait_ticks;
            end
        end
        if (repeat_left != 0) begin
            repeat_left = repeat_left - 1'b1;
            if (repeat_left == 0) begin
                sig         = 1'b1;
                repeat_left = repeat_ticks;
            end
        end
        prev_raw    = raw;
        rpt.held    = qual_levels;
        rpt.changed = chg;
        return sig;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            valid_ticks  = VALID_TIME_RST;
            wait_ticks   = WAIT_TIME_RST;
            repeat_ticks = REPEAT_PERIOD_RST;
            for (int b = 0; b < BTN_W; b++) begin
                release_left[b] = '0;
                press_left[b]   = '0;
            end
            repeat_left = '0;
            qual_levels = '0;
            prev_raw    = '0;
            reports_due.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                o_beats_out++;
                got.held    = out_ch.held_buttons;
                got.changed = out_ch.changed_buttons;
                if (reports_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat held=%b changed=%b",
                                            got.held, got.changed));
                end else begin
                    want = reports_due.pop_front();
                    if (got.held !== want.held)
                        flag_mismatch($sformatf("held_buttons %b, expected %b",
                                                got.held, want.held));
                    if (got.changed !== want.changed)
                        flag_mismatch($sformatf("changed_buttons %b, expected %b",
                                                got.changed, want.changed));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                o_beats_in++;
                if (debounce_tick(in_ch.raw_buttons, fresh))
                    reports_due.push_back(fresh);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_VALID_TIME:    valid_ticks  = i_cfg_data;
                    CFG_WAIT_TIME:     wait_ticks   = i_cfg_data;
                    CFG_REPEAT_PERIOD: repeat_ticks = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= reports_due.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the debounce/autorepeat testbench: clock, reset, stimulus, idling and the verdict.
// Depends on fbd_pkg, fbd_in_if, fbd_out_if, fbd_report_checker and the core.
`timescale 1ns / 100ps
module testbench;
    import fbd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 56;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    int mismatches;
    int pending;
    int beats_in;
    int beats_out;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_ask     = 0;
    int hold_seen    = 0;
    int hold_len     = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    logic [BTN_W-1:0] cur_raw = '0;
    int               run_left = 0;

    logic [BTN_W-1:0] opening [17] = '{
        5'h00, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h00, 5'h01, 5'h00,
        5'h00, 5'h00, 5'h00,
        5'h02, 5'h02, 5'h00, 5'h02, 5'h02, 5'h02
    };

    fbd_in_if  in_ch ();
    fbd_out_if out_ch ();

    five_button_debounce_autorepeat_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    fbd_report_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_beats_in   (beats_in),
        .o_beats_out  (beats_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding", cycle_count, pending);
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: random stalls plus the occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_ask) begin
            hold_seen    <= hold_ask;
            hold_left    <= hold_len;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input logic [BTN_W-1:0] raw);
        if (tx_idle_pct != 0) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid       <= 1'b1;
        in_ch.raw_buttons <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // with input valid dropped, let every outstanding report out
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] vt, input logic [CFG_W-1:0] wt,
                             input logic [CFG_W-1:0] rp);
        write_one(CFG_VALID_TIME, vt);
        write_one(CFG_WAIT_TIME, wt);
        write_one(CFG_REPEAT_PERIOD, rp);
    endtask

    // held runs of random patterns, single-bit edges and one-tick glitches
    task automatic random_items(input int count);
        int k;
        int pick;
        for (k = 0; k < count; k++) begin
            if (run_left == 0) begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    cur_raw  = BTN_W'($urandom);
                    run_left = 1;
                end else if (pick < 55) begin
                    cur_raw  = cur_raw ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
                    run_left = $urandom_range(1, 12);
                end else begin
                    cur_raw  = BTN_W'($urandom);
                    run_left = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                         : $urandom_range(1, 12);
                end
            end
            send_item(cur_raw);
            run_left--;
        end
    endtask

    initial begin
        int ph;
        int k;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_VALID_TIME;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.raw_buttons <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: full press and release, press during release time,
        // early release resumed from the stopped count
        for (k = 0; k < 17; k++)
            send_item(opening[k]);
        settle();

        // spare register index is ignored; zero valid time never qualifies
        write_one(CFG_IDX_SPARE, 8'hFF);
        write_one(CFG_VALID_TIME, 8'd0);
        send_item(5'h04);
        send_item(5'h04);
        send_item(5'h00);
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: load_regs(8'd3, 8'd3, 8'd10);
                1: load_regs(8'd0, 8'd0, 8'd0);
                2: load_regs(8'd255, 8'd255, 8'd255);
                3: load_regs(8'd1, 8'd1, 8'd1);
                4: load_regs(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)),
                             CFG_W'($urandom_range(0, 16)));
                5: load_regs(8'd2, 8'd5, 8'd255);
                6: load_regs(CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(0, 255)),
                             CFG_W'($urandom_range(1, 30)));
                default: load_regs(VALID_TIME_RST, WAIT_TIME_RST, REPEAT_PERIOD_RST);
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 63; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 63; end
                default: begin tx_idle_pct = 21; rx_stall_pct <= 21; end
            endcase
            if (ph == 0) begin
                hold_len <= LONG_HOLD;
                hold_ask <= hold_ask + 1;
            end
            random_items(PHASE_ITEMS);
            settle();
        end

        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        settle();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d input beats and %0d report beats over %0d register settings,",
                 beats_in, beats_out, NUM_PHASES + 2);
        $display("summary: all idling mixes, extreme timer values and one long output hold-off");
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
